>>> rtl/spfg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spfg_pkg
// Shared types, register indexes and saturation helper for the sample
// pre-emphasis, filter and gate block.
// ----------------------------------------------------------------------------
package spfg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W    = 19;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_PREEMPH_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREEMPH_ALP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILT_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_FB     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_EN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_THR    = 3'd6;

    // Filter modes. Code 3 behaves as high-pass.
    localparam logic [1:0] FMODE_OFF = 2'd0;
    localparam logic [1:0] FMODE_LP  = 2'd1;
    localparam logic [1:0] FMODE_HP  = 2'd2;

    localparam logic [COEF_W-1:0] ALPHA_RESET = 16'd63570;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                preemph_en;
        logic [COEF_W-1:0]   alpha;
        logic [1:0]          mode;
        logic [COEF_W-1:0]   gain;
        logic [COEF_W-1:0]   feedback;
        logic                gate_en;
        logic [COEF_W-1:0]   threshold;
    } t_cfg;

    typedef struct packed {
        logic                       last;
        logic signed [SAMPLE_W-1:0] sample;
    } t_item;

    // Clamp a wide signed sum to the 16-bit sample range.
    function automatic logic signed [SAMPLE_W-1:0] sat16(
        input logic signed [SUM_W-1:0] v
    );
        logic all_same;
        all_same = (v[SUM_W-1:SAMPLE_W-1] == {(SUM_W-SAMPLE_W+1){1'b0}}) ||
                   (v[SUM_W-1:SAMPLE_W-1] == {(SUM_W-SAMPLE_W+1){1'b1}});
        if (all_same) begin
            return v[SAMPLE_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/spfg_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spfg_front
// Accepts raw samples, applies pre-emphasis, counts frame position and
// pushes the result into the queue.
// ----------------------------------------------------------------------------
module spfg_front #(
    parameter int FRAME_SAMPLES = 256
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  spfg_pkg::t_cfg              i_cfg,
    input  wire                         i_valid,
    input  wire [spfg_pkg::SAMPLE_W-1:0] i_sample,
    output logic                        o_ready,
    input  wire                         i_full,
    output logic                        o_push,
    output spfg_pkg::t_item             o_item
);
    import spfg_pkg::*;

    localparam int POS_W = $clog2(FRAME_SAMPLES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_SAMPLES - 1);

    logic signed [SAMPLE_W-1:0] r_last_raw;
    logic [POS_W-1:0]           r_pos;
    logic [POS_W-1:0]           n_pos;

    logic signed [SAMPLE_W-1:0] raw;
    logic signed [2*SAMPLE_W:0] pe_prod;
    logic signed [SAMPLE_W:0]   pe_term;
    logic signed [SUM_W-1:0]    pe_diff;
    logic                       frame_end;

    assign raw     = $signed(i_sample);
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Taking the upper bits of the product floors toward minus infinity.
    assign pe_prod = $signed({1'b0, i_cfg.alpha}) * r_last_raw;
    assign pe_term = pe_prod[2*SAMPLE_W:SAMPLE_W];
    assign pe_diff = SUM_W'(raw) - SUM_W'(pe_term);

    assign frame_end = (r_pos == POS_LAST);
    assign n_pos     = frame_end ? '0 : r_pos + 1'b1;

    always_comb begin
        o_item.last   = frame_end;
        o_item.sample = i_cfg.preemph_en ? sat16(pe_diff) : raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= '0;
            r_pos      <= '0;
        end else if (o_push) begin
            r_pos <= n_pos;
            // The previous sample is tracked only while pre-emphasis is on.
            if (i_cfg.preemph_en) begin
                r_last_raw <= raw;
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/spfg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spfg_fifo
// Short queue that decouples the pre-emphasis front from the filter back.
// ----------------------------------------------------------------------------
module spfg_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  spfg_pkg::t_item  i_item,
    input  wire              i_pop,
    output spfg_pkg::t_item  o_item,
    output logic             o_full,
    output logic             o_empty
);
    import spfg_pkg::*;

    t_item              r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // The depth is a power of two, so the pointers wrap on their own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == Q_CNT_W'($past(r_count) + 1'b1))
        else $error("queue count did not advance on a push");

endmodule
`default_nettype wire

>>> rtl/spfg_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spfg_back
// Runs the one-pole filter on queued samples, then the noise gate, and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module spfg_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  spfg_pkg::t_cfg               i_cfg,
    input  wire                          i_filt_clear,
    input  spfg_pkg::t_item              i_item,
    input  wire                          i_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [spfg_pkg::SAMPLE_W-1:0] o_data,
    output logic                         o_last
);
    import spfg_pkg::*;

    logic signed [SAMPLE_W-1:0] r_y_mem;
    logic signed [SAMPLE_W-1:0] r_x_mem;

    logic                       r_a_valid;
    logic signed [SAMPLE_W-1:0] r_a_data;
    logic                       r_a_last;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;
    logic                       r_out_last;

    logic                       a_adv;
    logic                       b_adv;
    logic                       mode_off;
    logic                       mode_lp;
    logic signed [SAMPLE_W:0]   diff;
    logic signed [2*SAMPLE_W+1:0] p_gain;
    logic signed [2*SAMPLE_W:0] p_fb;
    logic signed [SUM_W-1:0]    filt_sum;
    logic signed [SAMPLE_W-1:0] filt_y;
    logic signed [SAMPLE_W-1:0] stage_y;
    logic signed [SAMPLE_W:0]   a_ext;
    logic [SAMPLE_W:0]          a_mag;
    logic                       gated;

    assign b_adv = !r_out_valid || i_ready;
    assign a_adv = !r_a_valid || b_adv;
    assign o_pop = !i_empty && a_adv;

    assign mode_off = (i_cfg.mode == FMODE_OFF);
    assign mode_lp  = (i_cfg.mode == FMODE_LP);

    // High-pass keeps the 17-bit difference unsaturated into the product.
    assign diff     = mode_lp ? (SAMPLE_W+1)'(i_item.sample)
                              : (SAMPLE_W+1)'(i_item.sample) - (SAMPLE_W+1)'(r_x_mem);
    assign p_gain   = $signed({1'b0, i_cfg.gain}) * diff;
    assign p_fb     = $signed({1'b0, i_cfg.feedback}) * r_y_mem;
    assign filt_sum = SUM_W'($signed(p_gain[2*SAMPLE_W+1:SAMPLE_W])) +
                      SUM_W'($signed(p_fb[2*SAMPLE_W:SAMPLE_W]));
    assign filt_y   = sat16(filt_sum);
    assign stage_y  = mode_off ? i_item.sample : filt_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_mem <= '0;
            r_x_mem <= '0;
        end else if (i_filt_clear) begin
            r_y_mem <= '0;
            r_x_mem <= '0;
        end else if (o_pop && !mode_off) begin
            r_y_mem <= filt_y;
            if (!mode_lp) begin
                r_x_mem <= i_item.sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_adv) begin
            r_a_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_data <= stage_y;
            r_a_last <= i_item.last;
        end
    end

    // Gate: zero a sample whose magnitude stays below the threshold.
    assign a_ext = (SAMPLE_W+1)'(r_a_data);
    assign a_mag = a_ext[SAMPLE_W] ? $unsigned(-a_ext) : $unsigned(a_ext);
    assign gated = i_cfg.gate_en && (a_mag < {1'b0, i_cfg.threshold});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_adv) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv && r_a_valid) begin
            r_out_data <= gated ? '0 : r_a_data;
            r_out_last <= r_a_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

    a_off_holds_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && mode_off && !i_filt_clear) |=> ($stable(r_y_mem) && $stable(r_x_mem)))
        else $error("filter memories changed while the filter is off");

    a_lp_holds_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && mode_lp && !i_filt_clear) |=> $stable(r_x_mem))
        else $error("input memory changed in low-pass mode");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_filt_clear |=> (r_y_mem == '0 && r_x_mem == '0))
        else $error("filter memories not cleared after a filter register write");

endmodule
`default_nettype wire

>>> rtl/sample_preemphasis_filter_gate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sample_preemphasis_filter_gate
// Pre-emphasis, one-pole filter and noise gate on a 16-bit sample stream.
// ----------------------------------------------------------------------------
// The block takes one signed sample per cycle and returns one cleaned sample
// per cycle while the output is not stalled. The front stage does the
// pre-emphasis multiply-subtract and counts the frame position, a two-entry
// queue follows, and the back stage runs the filter as two multiplies and an
// add per sample; its feedback register updates as each sample is filtered,
// which keeps the rate of one sample per cycle. The noise gate sits in the
// output register. tlast marks every FRAME_SAMPLES-th sample. Writing the
// filter mode or either filter coefficient clears the filter history.
// Configuration must be written only while no samples are in flight.
// ----------------------------------------------------------------------------
module sample_preemphasis_filter_gate #(
    parameter int FRAME_SAMPLES = 256
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // Input stream. tdata: raw_sample [15:0].
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire [15:0]                     i_s_tdata,
    // Output stream. tdata: clean_sample [15:0]; tlast: frame_last.
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    output logic [15:0]                    o_m_tdata,
    output logic                           o_m_tlast,
    // Configuration writes.
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [spfg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire [spfg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spfg_pkg::*;

    t_cfg  r_cfg;
    logic  r_filt_clear;
    logic  n_filt_clear;
    logic  cfg_wr;

    t_item front_item;
    t_item queue_item;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_filt_clear = 1'b0;
        if (cfg_wr) begin
            case (i_cfg_index) inside
                CFG_FILT_MODE, CFG_COEF_GAIN, CFG_COEF_FB: n_filt_clear = 1'b1;
                default:                                   n_filt_clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.preemph_en <= 1'b1;
            r_cfg.alpha      <= ALPHA_RESET;
            r_cfg.mode       <= FMODE_OFF;
            r_cfg.gain       <= '0;
            r_cfg.feedback   <= '0;
            r_cfg.gate_en    <= 1'b0;
            r_cfg.threshold  <= '0;
            r_filt_clear     <= 1'b0;
        end else begin
            r_filt_clear <= n_filt_clear;
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_PREEMPH_EN:  r_cfg.preemph_en <= i_cfg_data[0];
                    CFG_PREEMPH_ALP: r_cfg.alpha      <= i_cfg_data;
                    CFG_FILT_MODE:   r_cfg.mode       <= i_cfg_data[1:0];
                    CFG_COEF_GAIN:   r_cfg.gain       <= i_cfg_data;
                    CFG_COEF_FB:     r_cfg.feedback   <= i_cfg_data;
                    CFG_GATE_EN:     r_cfg.gate_en    <= i_cfg_data[0];
                    CFG_GATE_THR:    r_cfg.threshold  <= i_cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    spfg_front #(
        .FRAME_SAMPLES (FRAME_SAMPLES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_tvalid),
        .i_sample (i_s_tdata),
        .o_ready  (o_s_tready),
        .i_full   (full),
        .o_push   (push),
        .o_item   (front_item)
    );

    spfg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_full  (full),
        .o_empty (empty)
    );

    spfg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_filt_clear (r_filt_clear),
        .i_item       (queue_item),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_data       (o_m_tdata),
        .o_last       (o_m_tlast)
    );

endmodule
`default_nettype wire

>>> test/sample_preemphasis_filter_gate_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_preemphasis_filter_gate_tb
// Self-checking bench for the pre-emphasis, one-pole filter and noise gate
// block. A predictor in the bench follows every accepted sample and queues
// the cleaned sample and frame flag it must produce; each output request is
// checked against the oldest entry. Directed cases cover the sample extremes,
// every filter mode and the gate limits, then random settings and samples
// run with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module sample_preemphasis_filter_gate_tb;

    import spfg_pkg::*;

    localparam int FRAME_LEN = 256;
    localparam int GAP_MAX = 18;
    localparam int CYCLE_LIMIT = 500000;
    localparam int REPORT_MAX = 10;

    // Index beyond the register map; writes to it must have no effect.
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;
    // Mode code 3 is decoded as high-pass.
    localparam logic [1:0] FMODE_HP_ALT = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_s_tvalid;
    logic o_s_tready;
    logic [15:0] i_s_tdata;
    logic o_m_tvalid;
    logic i_m_tready;
    logic [15:0] o_m_tdata;
    logic o_m_tlast;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sample_preemphasis_filter_gate #(
        .FRAME_SAMPLES(FRAME_LEN)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tlast(o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the settings and the sample history.
    logic pe_en;
    logic [COEF_W-1:0] pe_alpha;
    logic [1:0] f_mode;
    logic [COEF_W-1:0] f_gain;
    logic [COEF_W-1:0] f_fb;
    logic g_en;
    logic [COEF_W-1:0] g_thr;
    logic signed [SAMPLE_W-1:0] prev_raw;
    logic signed [SAMPLE_W-1:0] y_mem;
    logic signed [SAMPLE_W-1:0] x_mem;
    int unsigned frame_pos;

    t_item cleaned_q[$];
    int mismatches = 0;
    int cycle_count = 0;
    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int rx_wait = 0;
    int rx_hold_left = 0;

    function automatic longint q16_mul(input logic [COEF_W-1:0] c, input longint v);
        longint p;
        p = longint'(c) * v;
        // Arithmetic shift of a signed value rounds toward minus infinity.
        return p >>> 16;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] clamp16(input longint v);
        if (v > 32767) begin
            return 16'sd32767;
        end else if (v < -32768) begin
            return -16'sd32768;
        end else begin
            return v[SAMPLE_W-1:0];
        end
    endfunction

    function automatic t_item run_chain(input logic signed [SAMPLE_W-1:0] raw);
        logic signed [SAMPLE_W-1:0] v;
        logic signed [SAMPLE_W-1:0] y;
        longint diff;
        longint mag;
        t_item r;
        v = raw;
        if (pe_en) begin
            v = clamp16(longint'(raw) - q16_mul(pe_alpha, longint'(prev_raw)));
            prev_raw = raw;
        end
        if (f_mode == FMODE_LP) begin
            y_mem = clamp16(q16_mul(f_gain, longint'(v)) +
                            q16_mul(f_fb, longint'(y_mem)));
            v = y_mem;
        end else if (f_mode != FMODE_OFF) begin
            // The difference keeps its full 17-bit range until the multiply.
            diff = longint'(v) - longint'(x_mem);
            y = clamp16(q16_mul(f_gain, diff) + q16_mul(f_fb, longint'(y_mem)));
            x_mem = v;
            y_mem = y;
            v = y;
        end
        if (g_en) begin
            mag = (v < 0) ? -longint'(v) : longint'(v);
            if (mag < longint'(g_thr)) begin
                v = '0;
            end
        end
        if (frame_pos >= FRAME_LEN - 1) begin
            r.last = 1'b1;
            frame_pos = 0;
        end else begin
            r.last = 1'b0;
            frame_pos++;
        end
        r.sample = v;
        return r;
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PREEMPH_EN: pe_en = data[0];
            CFG_PREEMPH_ALP: pe_alpha = data;
            CFG_FILT_MODE: f_mode = data[1:0];
            CFG_COEF_GAIN: f_gain = data;
            CFG_COEF_FB: f_fb = data;
            CFG_GATE_EN: g_en = data[0];
            CFG_GATE_THR: g_thr = data;
            default: return;
        endcase
        if (idx == CFG_FILT_MODE || idx == CFG_COEF_GAIN || idx == CFG_COEF_FB) begin
            y_mem = '0;
            x_mem = '0;
        end
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= s;
        do @(posedge i_clk); while (!o_s_tready);
        cleaned_q.push_back(run_chain(s));
        @(negedge i_clk);
    endtask

    // Leaves the channel valid so back-to-back writes can follow without a gap.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        store_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (cleaned_q.size() != 0);
    endtask

    task automatic apply_settings(input logic [15:0] pe, input logic [15:0] alpha,
                                  input logic [15:0] mode, input logic [15:0] gain,
                                  input logic [15:0] fb, input logic [15:0] gate,
                                  input logic [15:0] thr);
        drain_results();
        write_reg(CFG_PREEMPH_EN, pe);
        write_reg(CFG_PREEMPH_ALP, alpha);
        write_reg(CFG_FILT_MODE, mode);
        write_reg(CFG_COEF_GAIN, gain);
        write_reg(CFG_COEF_FB, fb);
        write_reg(CFG_GATE_EN, gate);
        write_reg(CFG_GATE_THR, thr);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'h8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_threshold();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            3: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 3000));
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sd32767;
            1: return -16'sd32768;
            2: return 16'($urandom_range(0, 400) - 200);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Output side: a long hold-off takes priority over the per-request stall.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else if (rx_wait > 0) begin
            i_m_tready <= 1'b0;
            rx_wait = rx_wait - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_item want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            rx_wait = $urandom_range(0, rx_gap_max);
            if (cleaned_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("cycle %0d: result %0d arrived with nothing outstanding",
                             cycle_count, $signed(o_m_tdata));
                end
            end else begin
                want = cleaned_q.pop_front();
                if (o_m_tdata !== want.sample || o_m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("cycle %0d: clean_sample exp %0d got %0d, %s%0b got %0b",
                                 cycle_count, want.sample, $signed(o_m_tdata),
                                 "frame_last exp ", want.last, o_m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_reset_defaults();
        tx_gap_max = 0;
        rx_gap_max = 0;
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd0);
        send_sample(-16'sd1);
    endtask

    task automatic test_directed_modes();
        tx_gap_max = GAP_MAX;
        rx_gap_max = GAP_MAX;
        // Enable written with upper bits set; only bit 0 counts, so it is off.
        apply_settings(16'hFFFE, 16'd0, FMODE_LP, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        // Mode written as all ones lands on the high-pass alias; the gate at
        // 32768 passes only a full-scale negative sample.
        apply_settings(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'd1, 16'd32768);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd100);
        send_sample(-16'sd32768);
        // Threshold above any magnitude zeroes everything.
        apply_settings(16'd1, 16'd0, FMODE_OFF, 16'd0, 16'd0, 16'd1, 16'hFFFF);
        send_sample(-16'sd32768);
        send_sample(16'sd5);
        apply_settings(16'd0, 16'd0, FMODE_HP, 16'h8000, 16'd0, 16'd1, 16'd1000);
        @(negedge i_clk);
        write_reg(CFG_NO_REG, 16'($urandom_range(0, 65535)));
        i_cfg_valid <= 1'b0;
        send_sample(16'sd999);
        send_sample(-16'sd1000);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
    endtask

    task automatic test_backpressure();
        apply_settings(16'd1, 16'd63570, FMODE_LP, 16'h4000, 16'hC000, 16'd0, 16'd0);
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold_left = 150;
        repeat (40) send_sample(pick_sample());
        // The sender stops here until every outstanding result is back.
        drain_results();
        rx_gap_max = GAP_MAX;
        repeat (40) send_sample(pick_sample());
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 10; phase++) begin
            apply_settings(16'($urandom_range(0, 1)), pick_coef(), 16'(phase % 4),
                           pick_coef(), pick_coef(), 16'($urandom_range(0, 1)),
                           pick_threshold());
            tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            repeat (150) send_sample(pick_sample());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        pe_en = 1'b1;
        pe_alpha = ALPHA_RESET;
        f_mode = FMODE_OFF;
        f_gain = '0;
        f_fb = '0;
        g_en = 1'b0;
        g_thr = '0;
        prev_raw = '0;
        y_mem = '0;
        x_mem = '0;
        frame_pos = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_directed_modes();
        test_backpressure();
        test_random_settings();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && cleaned_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
